[src/apc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants, types and the float compare for the argmax pooling block.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_WINDOW   = 256;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int POS_W        = $clog2(MAX_WINDOW);
    localparam int VAL_W        = 32;
    localparam int WIN_W        = 9;
    localparam int CNT_W        = 11;
    localparam int ADDR_W       = 3;

    typedef enum logic [ADDR_W-1:0] {
        REG_WINDOW   = 3'd0,
        REG_CHANNELS = 3'd4
    } t_reg_addr;

    // control that travels with a beat into the store stage
    typedef struct packed {
        logic             first;
        logic             last_elem;
        logic             last_chan;
        logic [POS_W-1:0] pos;
    } t_beat_ctl;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] max_bits;
        logic [POS_W-1:0] pos;
        logic             last_chan;
    } t_result;

    function automatic logic is_nan(input logic [VAL_W-1:0] x);
        is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] x);
        order_key = x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    // IEEE ordered a > b
    function automatic logic ordered_gt(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b);
        logic zeros;
        zeros = ((a[30:0] | b[30:0]) == 31'd0);
        ordered_gt = !is_nan(a) && !is_nan(b) && !zeros && (order_key(a) > order_key(b));
    endfunction

endpackage
`default_nettype wire

[src/apc_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apc_store
// Per-channel running max/position memory with read-modify-write and
// forwarding of the last write for back-to-back beats on one channel.
// ----------------------------------------------------------------------------
module apc_store
    import apc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_accept,
    input  wire logic [CH_W-1:0]  i_addr,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire t_beat_ctl        i_ctl,
    output t_result               o_res
);

    localparam int ENT_W = VAL_W + POS_W;

    logic [ENT_W-1:0] r_mem [MAX_CHANNELS];
    logic [ENT_W-1:0] r_rdata;
    logic             r_s2_valid;
    t_beat_ctl        r_s2_ctl;
    logic [CH_W-1:0]  r_s2_addr;
    logic [VAL_W-1:0] r_s2_value;
    logic             r_fwd_valid;
    logic [CH_W-1:0]  r_fwd_addr;
    logic [ENT_W-1:0] r_fwd_data;

    logic [ENT_W-1:0] w_old;
    logic [ENT_W-1:0] n_entry;
    logic             w_we;

    assign w_we  = r_s2_valid && i_adv;
    // memory reads before write; the write of the previous beat comes from r_fwd
    assign w_old = (r_fwd_valid && r_fwd_addr == r_s2_addr) ? r_fwd_data : r_rdata;

    always_comb begin
        if (r_s2_ctl.first) begin
            n_entry = {r_s2_value, {POS_W{1'b0}}};
        end else if (ordered_gt(r_s2_value, w_old[ENT_W-1:POS_W])) begin
            n_entry = {r_s2_value, r_s2_ctl.pos};
        end else begin
            n_entry = w_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= r_mem[i_addr];
        end
        if (w_we) begin
            r_mem[r_s2_addr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_s2_valid <= i_accept;
            end
            if (w_we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_ctl   <= i_ctl;
            r_s2_addr  <= i_addr;
            r_s2_value <= i_value;
        end
        if (w_we) begin
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= n_entry;
        end
    end

    assign o_res.valid     = r_s2_valid && r_s2_ctl.last_elem;
    assign o_res.max_bits  = n_entry[ENT_W-1:POS_W];
    assign o_res.pos       = n_entry[POS_W-1:0];
    assign o_res.last_chan = r_s2_ctl.last_chan;

endmodule
`default_nettype wire

[src/argmax_pooling_per_channel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// argmax_pooling_per_channel
// Per-channel max pooling with argmax over float32 beats.
//
// Input channel: i_valid/o_stall/i_value_bits, one value per beat, ordered
// element-major, channel-minor. A beat is taken when i_valid && !o_stall.
// Output channel: o_valid/i_stall with max, position and last-channel flag,
// one result per beat of the window's last element.
// Throughput: one beat per cycle while o_stall is low; the channel memory is
// read at accept and written back from the store stage, with the last write
// forwarded, so beats on the same channel may follow each other directly.
// Output path: a result passes the store stage and then the output register.
// When the receiver stalls a valid result, o_stall rises and the pipe holds.
// Reset clears counters and pipe; window_size=9, channel_count=1. The
// memory has no reset: every entry is loaded by a window's first element.
// APB: window_size at 0x0, channel_count at 0x4; pready always high.
// ----------------------------------------------------------------------------
module argmax_pooling_per_channel
    import apc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [VAL_W-1:0]  i_value_bits,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [VAL_W-1:0]       o_max_bits,
    output logic [POS_W-1:0]       o_max_position,
    output logic                   o_last_channel
);

    logic [WIN_W-1:0] r_window;
    logic [CNT_W-1:0] r_chans;
    logic [CH_W-1:0]  r_chan;
    logic [POS_W-1:0] r_elem;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_max;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_last;

    logic [WIN_W-1:0] w_win_m1;
    logic [CH_W-1:0]  w_chan_m1;
    logic             w_adv;
    logic             w_accept;
    logic             w_last_elem;
    logic             w_last_chan;
    logic             w_wr;
    t_beat_ctl        w_ctl;
    t_result          w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        case (t_reg_addr'(paddr))
            REG_WINDOW:   prdata = {{(32-WIN_W){1'b0}}, r_window};
            REG_CHANNELS: prdata = {{(32-CNT_W){1'b0}}, r_chans};
            default:      prdata = 32'd0;
        endcase
    end

    // clamp registers to 1..max, then take the last index
    always_comb begin
        if (r_window == '0) begin
            w_win_m1 = '0;
        end else if (r_window > WIN_W'(MAX_WINDOW)) begin
            w_win_m1 = WIN_W'(MAX_WINDOW - 1);
        end else begin
            w_win_m1 = r_window - WIN_W'(1);
        end
        if (r_chans == '0) begin
            w_chan_m1 = '0;
        end else if (r_chans > CNT_W'(MAX_CHANNELS)) begin
            w_chan_m1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            w_chan_m1 = CH_W'(r_chans - CNT_W'(1));
        end
    end

    assign w_adv       = !(r_out_valid && i_stall);
    assign o_stall     = !w_adv;
    assign w_accept    = i_valid && w_adv;
    assign w_last_elem = {1'b0, r_elem} >= w_win_m1;
    assign w_last_chan = r_chan >= w_chan_m1;

    assign w_ctl.first     = (r_elem == '0);
    assign w_ctl.last_elem = w_last_elem;
    assign w_ctl.last_chan = w_last_chan;
    assign w_ctl.pos       = r_elem;

    apc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_accept (w_accept),
        .i_addr   (r_chan),
        .i_value  (i_value_bits),
        .i_ctl    (w_ctl),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WIN_W'(9);
            r_chans     <= CNT_W'(1);
            r_chan      <= '0;
            r_elem      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr && t_reg_addr'(paddr) == REG_WINDOW) begin
                r_window <= pwdata[WIN_W-1:0];
            end
            if (w_wr && t_reg_addr'(paddr) == REG_CHANNELS) begin
                r_chans <= pwdata[CNT_W-1:0];
            end
            if (w_accept) begin
                if (w_last_chan) begin
                    r_chan <= '0;
                    r_elem <= w_last_elem ? '0 : r_elem + POS_W'(1);
                end else begin
                    r_chan <= r_chan + CH_W'(1);
                end
            end
            if (w_adv) begin
                r_out_valid <= w_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_max  <= w_res.max_bits;
            r_out_pos  <= w_res.pos;
            r_out_last <= w_res.last_chan;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_max_bits     = r_out_max;
    assign o_max_position = r_out_pos;
    assign o_last_channel = r_out_last;

    a_stall_only_on_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a held result");

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_max_position} <= w_win_m1))
        else $error("argmax position beyond window");

    a_first_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_win_m1 == '0) |-> (o_max_position == '0))
        else $error("single-element window gave nonzero position");

endmodule
`default_nettype wire
